@@ rtl/core/s88bsm_pkg.sv @@
package s88bsm_pkg;

    // Store geometry
    localparam int MAX_MODULES = 62;
    localparam int MOD_W       = 6;
    localparam int PHASE_W     = 10;
    localparam int BIT_W       = 9;

    // Stream widths
    localparam int S_DATA_W = 8;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 16;

    // Tick schedule phases
    localparam logic [PHASE_W-1:0] PH_PS_HI    = PHASE_W'(3);
    localparam logic [PHASE_W-1:0] PH_CLK_HI   = PHASE_W'(4);
    localparam logic [PHASE_W-1:0] PH_SAMPLE0  = PHASE_W'(5);
    localparam logic [PHASE_W-1:0] PH_RST_HI   = PHASE_W'(9);
    localparam logic [PHASE_W-1:0] PH_RST_LO   = PHASE_W'(10);
    localparam logic [PHASE_W-1:0] PH_PS_LO    = PHASE_W'(11);
    localparam logic [PHASE_W-1:0] PH_DATA     = PHASE_W'(12);
    localparam logic [PHASE_W-1:0] SCAN_HEAD   = PHASE_W'(10);

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_READ = 2'd1,
        OP_ACK  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_UNCHANGED = 2'd0,
        ST_READING   = 2'd1,
        ST_CHANGED   = 2'd2
    } scan_status_t;

    // Bus line levels
    typedef struct packed {
        logic rst;
        logic clk;
        logic ps;
    } pins_t;

    // Item state handed from the scheduler stage to the update stage
    typedef struct packed {
        op_t              op;
        logic             level;
        logic             sample;    // tick samples an in-range store bit
        logic [2:0]       bit_pos;
        logic             end_scan;  // tick closes the scan
        logic             rd_hit;    // read op addresses an active module
        logic [MOD_W-1:0] addr;
        pins_t            pins;      // line levels after this item
    } s1_info_t;

endpackage

@@ rtl/core/s88bsm_ram.sv @@
module s88bsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 62
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, old data on a same-cycle write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/s88bsm_sched.sv @@
module s88bsm_sched (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [s88bsm_pkg::MOD_W-1:0] cfg_wr_data,
    input  logic                       accept,
    input  logic                       advance,
    input  logic [1:0]                 in_op,
    input  logic                       in_level,
    input  logic [s88bsm_pkg::MOD_W-1:0] in_index,
    output logic                       ram_re,
    output logic [s88bsm_pkg::MOD_W-1:0] ram_raddr,
    output logic                       s1_valid,
    output s88bsm_pkg::s1_info_t       s1_info
);

    import s88bsm_pkg::*;

    logic [MOD_W-1:0]   module_count_reg;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [BIT_W-1:0]   bit_idx_reg, bit_idx_next;
    pins_t              pins_reg, pins_next;
    logic               s1_valid_reg, s1_valid_next;
    s1_info_t           s1_reg, s1_next;

    logic [MOD_W-1:0]   m_act;
    logic [PHASE_W-1:0] limit;
    logic [PHASE_W-1:0] phase_inc;
    logic [MOD_W-1:0]   sample_mod;
    logic               sample_phase;
    logic               do_tick;
    op_t                op;

    assign op = op_t'(in_op);

    // Active module count, zero when the bus is off
    always_comb
    begin
        if (module_count_reg != '0 && module_count_reg <= MOD_W'(MAX_MODULES))
        begin
            m_act = module_count_reg;
        end
        else
        begin
            m_act = '0;
        end
    end

    assign limit      = SCAN_HEAD + PHASE_W'({m_act, 4'b0000});
    assign phase_inc  = phase_reg + PHASE_W'(1);
    assign sample_mod = bit_idx_reg[BIT_W-1:3];
    assign do_tick    = accept && (op == OP_TICK) && (m_act != '0);

    // Tick schedule: line levels, sampling, counter advance and scan end; item payload for every accepted op
    always_comb
    begin
        pins_next    = pins_reg;
        phase_next   = phase_reg;
        bit_idx_next = bit_idx_reg;
        sample_phase = 1'b0;
        s1_next      = s1_reg;

        if (do_tick)
        begin
            if (phase_reg == PH_PS_HI)
            begin
                pins_next.ps = 1'b1;
            end
            if (phase_reg == PH_CLK_HI)
            begin
                pins_next.clk = 1'b1;
            end
            if (phase_reg == PH_SAMPLE0)
            begin
                pins_next.clk = 1'b0;
                sample_phase  = 1'b1;
            end
            if (phase_reg == PH_RST_HI)
            begin
                pins_next.rst = 1'b1;
            end
            if (phase_reg == PH_RST_LO)
            begin
                pins_next.rst = 1'b0;
            end
            if (phase_reg == PH_PS_LO)
            begin
                pins_next.ps = 1'b0;
            end
            if (phase_reg >= PH_DATA && phase_reg < limit)
            begin
                if (!phase_reg[0])
                begin
                    pins_next.clk = 1'b1;
                end
                else
                begin
                    pins_next.clk = 1'b0;
                    sample_phase  = 1'b1;
                end
            end
            if (sample_phase)
            begin
                bit_idx_next = bit_idx_reg + BIT_W'(1);
            end
            phase_next = phase_inc;
            if (phase_inc >= limit)
            begin
                phase_next   = '0;
                bit_idx_next = '0;
                pins_next    = '0;
            end
        end

        if (accept)
        begin
            s1_next.op       = op;
            s1_next.level    = in_level;
            s1_next.sample   = sample_phase && (sample_mod < m_act);
            s1_next.bit_pos  = bit_idx_reg[2:0];
            s1_next.end_scan = do_tick && (phase_inc >= limit);
            s1_next.rd_hit   = (op == OP_READ) && (in_index < m_act);
            s1_next.addr     = (op == OP_READ) ? in_index : sample_mod;
            s1_next.pins     = pins_next;
        end
    end

    // Store read is issued as the item enters
    assign ram_re    = accept && (s1_next.sample || s1_next.rd_hit);
    assign ram_raddr = s1_next.addr;

    // Stage occupancy
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            module_count_reg <= '0;
            phase_reg        <= '0;
            bit_idx_reg      <= '0;
            pins_reg         <= '0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                module_count_reg <= cfg_wr_data;
            end
            phase_reg    <= phase_next;
            bit_idx_reg  <= bit_idx_next;
            pins_reg     <= pins_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Item payload
    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_info  = s1_reg;

endmodule

@@ rtl/core/s88bsm_update.sv @@
module s88bsm_update (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  s88bsm_pkg::s1_info_t         s1_info,
    input  logic [7:0]                   ram_rdata,
    output logic                         ram_we,
    output logic [s88bsm_pkg::MOD_W-1:0] ram_waddr,
    output logic [7:0]                   ram_wdata,
    input  logic                         out_ready,
    output logic                         out_valid,
    output s88bsm_pkg::pins_t            out_pins,
    output logic [7:0]                   out_byte,
    output s88bsm_pkg::scan_status_t     out_status
);

    import s88bsm_pkg::*;

    logic [MAX_MODULES-1:0] written_reg, written_next;
    logic                   fwd_valid_reg;
    logic [MOD_W-1:0]       fwd_addr_reg;
    logic [7:0]             fwd_data_reg;
    scan_status_t           status_reg, status_next;
    logic                   out_valid_reg, out_valid_next;
    pins_t                  out_pins_reg;
    logic [7:0]             out_byte_reg, byte_next;
    scan_status_t           out_status_reg;

    logic [7:0]             old_byte;
    logic                   old_bit;
    logic                   bit_diff;

    // Stored byte: last write wins, never-written entries read as zero
    always_comb
    begin
        if (fwd_valid_reg && fwd_addr_reg == s1_info.addr)
        begin
            old_byte = fwd_data_reg;
        end
        else if (written_reg[s1_info.addr])
        begin
            old_byte = ram_rdata;
        end
        else
        begin
            old_byte = '0;
        end
    end

    assign old_bit  = old_byte[s1_info.bit_pos];
    assign bit_diff = s1_info.sample && (old_bit != s1_info.level);

    // Sample write-back, only when the sampled bit differs
    assign ram_we    = advance && bit_diff;
    assign ram_waddr = s1_info.addr;
    assign ram_wdata = old_byte ^ (8'd1 << s1_info.bit_pos);

    // Scan status update, in item order
    always_comb
    begin
        status_next = status_reg;
        if (s1_info.op == OP_ACK)
        begin
            status_next = ST_UNCHANGED;
        end
        if (bit_diff)
        begin
            status_next = ST_READING;
        end
        if (s1_info.end_scan && status_next == ST_READING)
        begin
            status_next = ST_CHANGED;
        end
    end

    assign byte_next = s1_info.rd_hit ? old_byte : 8'd0;

    always_comb
    begin
        written_next = written_reg;
        if (ram_we)
        begin
            written_next[ram_waddr] = 1'b1;
        end
    end

    // Result register occupancy
    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg   <= '0;
            fwd_valid_reg <= 1'b0;
            status_reg    <= ST_UNCHANGED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            written_reg   <= written_next;
            out_valid_reg <= out_valid_next;
            if (ram_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (advance)
            begin
                status_reg <= status_next;
            end
        end
    end

    // Forwarding copy and result payload
    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            fwd_addr_reg <= ram_waddr;
            fwd_data_reg <= ram_wdata;
        end
        if (advance)
        begin
            out_pins_reg   <= s1_info.pins;
            out_byte_reg   <= byte_next;
            out_status_reg <= status_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_pins   = out_pins_reg;
    assign out_byte   = out_byte_reg;
    assign out_status = out_status_reg;

    // Only a tick with an in-range sample writes the store
    a_we_tick : assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (s1_info.op == OP_TICK && s1_info.sample))
        else $error("store written by a non-sampling item");

    // Non-read items return a zero byte
    a_byte_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_info.op != OP_READ) |=> (out_byte_reg == 8'd0))
        else $error("read_byte nonzero on a non-read item");

    // Acknowledge clears the status
    a_ack : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_info.op == OP_ACK) |=> (out_status_reg == ST_UNCHANGED))
        else $error("acknowledge did not clear status");

    // A reading scan that ends is reported as changed
    a_end_scan : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_info.end_scan && (bit_diff || status_reg == ST_READING))
        |=> (out_status_reg == ST_CHANGED && status_reg == ST_CHANGED))
        else $error("scan end did not mark status changed");

endmodule

@@ rtl/core/s88_bus_scan_master.sv @@
// Channel    | Dir | Signals                      | Contents (low bit first)
// s_axis     | in  | s_tvalid s_tready s_tdata    | tdata: data_pin, module_index[5:0]
//            |     | s_tuser                      | tuser: op[1:0]
// m_axis     | out | m_tvalid m_tready m_tdata    | tdata: ps_level, clk_level,
//            |     |                              | reset_level, read_byte[7:0],
//            |     |                              | scan_status[1:0]
// config     | in  | cfg_wr_en cfg_wr_data        | module_count[5:0]
//
// Each item passes from input transfer through the schedule stage (store
// read issued) and then the update stage (store compare and write-back)
// to its result. One item is accepted per cycle while the result is not
// stalled; back-to-back samples of one store byte are forwarded from the
// last write. Reset clears the control state and the store's written
// flags, so the store reads as zero at once. A stalled result holds the
// update stage; input is still taken while the schedule stage can move on.
module s88_bus_scan_master (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [s88bsm_pkg::MOD_W-1:0]     cfg_wr_data,  // module_count
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [s88bsm_pkg::S_DATA_W-1:0]  s_tdata,      // data_pin, module_index
    input  logic [s88bsm_pkg::S_USER_W-1:0]  s_tuser,      // op
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [s88bsm_pkg::M_DATA_W-1:0]  m_tdata       // ps, clk, reset, byte, status
);

    import s88bsm_pkg::*;

    logic               accept;
    logic               advance;
    logic               s1_valid;
    s1_info_t           s1_info;
    logic               ram_re;
    logic [MOD_W-1:0]   ram_raddr;
    logic [7:0]         ram_rdata;
    logic               ram_we;
    logic [MOD_W-1:0]   ram_waddr;
    logic [7:0]         ram_wdata;
    logic               out_valid;
    pins_t              out_pins;
    logic [7:0]         out_byte;
    scan_status_t       out_status;

    // Handshake: the update stage moves when the result register frees up
    assign advance  = s1_valid && (!out_valid || m_tready);
    assign s_tready = !s1_valid || advance;
    assign accept   = s_tvalid && s_tready;

    s88bsm_sched u_sched (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .advance     (advance),
        .in_op       (s_tuser[1:0]),
        .in_level    (s_tdata[0]),
        .in_index    (s_tdata[MOD_W:1]),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .s1_valid    (s1_valid),
        .s1_info     (s1_info)
    );

    s88bsm_ram #(
        .WIDTH (8),
        .DEPTH (MAX_MODULES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    s88bsm_update u_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .s1_info    (s1_info),
        .ram_rdata  (ram_rdata),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .out_ready  (m_tready),
        .out_valid  (out_valid),
        .out_pins   (out_pins),
        .out_byte   (out_byte),
        .out_status (out_status)
    );

    // Result transfer
    assign m_tvalid = out_valid;
    assign m_tdata  = {3'b000, out_status, out_byte, out_pins.rst, out_pins.clk, out_pins.ps};

endmodule
